// File: rtl/pftd_pkg.sv
// Package for the trial-division prime factor block: widths, word types,
// divider status struct. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pftd_pkg;

    // Working width of the value being factored
    localparam int VALUE_BITS  = 31;
    // Field widths of the channel words
    localparam int VALUE_W     = 31;
    localparam int FACTOR_W    = 31;
    // Trial divisors never pass floor(sqrt(2**VALUE_BITS)) + 1
    localparam int D_BITS      = (VALUE_BITS + 1) / 2 + 1;
    localparam int MAX_RESULTS = 9;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int STEP_W      = $clog2(VALUE_BITS);

    typedef logic [VALUE_W-1:0]    value_t;
    typedef logic [FACTOR_W-1:0]   factor_t;
    typedef logic [VALUE_BITS-1:0] rem_t;
    typedef logic [D_BITS-1:0]     div_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        rem_t quot;
        logic rem_zero;
    } div_stat_t;

endpackage

`default_nettype wire

// File: rtl/pftd_in_if.sv
// Input channel of the prime factor block: valid/ready and the value word.
// Depends on pftd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pftd_in_if;
    import pftd_pkg::*;

    logic   valid;
    logic   ready;
    value_t value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// File: rtl/pftd_out_if.sv
// Output channel of the prime factor block: valid/ready and the result word.
// Depends on pftd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pftd_out_if;
    import pftd_pkg::*;

    logic    valid;
    logic    ready;
    factor_t factor;
    logic    no_factor;
    logic    last;

    modport source (output valid, output factor, output no_factor, output last, input ready);
    modport sink   (input valid, input factor, input no_factor, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/pftd_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, VALUE_BITS bits
// per division; reports quotient and whether the remainder is zero.
// Depends on pftd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pftd_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  pftd_pkg::rem_t      dividend,
    input  pftd_pkg::div_t      divisor,
    output pftd_pkg::div_stat_t stat
);
    import pftd_pkg::*;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    rem_t              num_reg, num_next;
    div_t              part_reg, part_next;
    div_t              dsr_reg, dsr_next;

    logic [D_BITS:0]   trial;
    logic [D_BITS:0]   diff;
    logic              fits;

    // Shift one dividend bit into the partial remainder and try the subtract
    always_comb
    begin
        trial = {part_reg, num_reg[VALUE_BITS-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = trial >= {1'b0, dsr_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        num_next  = num_reg;
        part_next = part_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            num_next  = dividend;
            part_next = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            part_next = fits ? diff[D_BITS-1:0] : trial[D_BITS-1:0];
            num_next  = {num_reg[VALUE_BITS-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(VALUE_BITS - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Datapath holds no reset
    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        part_reg <= part_next;
        dsr_reg  <= dsr_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.quot     = num_reg;
    assign stat.rem_zero = (part_reg == '0);

endmodule

`default_nettype wire

// File: rtl/prime_factors_trial_division.sv
// Top level of the trial-division prime factor block: sequencer, pending
// factor and output register around the bit-serial divider.
// Depends on pftd_pkg, pftd_in_if, pftd_out_if and pftd_div.
//
//   channel | dir | word fields              | accepted when
//   din     | in  | value                    | din.valid && din.ready
//   dout    | out | factor, no_factor, last  | dout.valid && dout.ready
//
// One word is factored at a time; din.ready is high only while idle.
// Each trial divisor, whether tried or divided out, costs one division
// followed by a decision step; a prime near 2**31 needs about 46341
// divisors. Inputs 0 and 1 skip the divider. A stalled dout holds the
// sequencer when a new factor must displace the one already waiting, and
// holds the final word until the output register is free.
// Reset clears all control state; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module prime_factors_trial_division (
    input  logic              clk,
    input  logic              rst_n,
    pftd_in_if.sink           din,
    pftd_out_if.source        dout
);
    import pftd_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0] state_reg, state_next;
    rem_t       rem_reg, rem_next;
    div_t       d_reg, d_next;
    logic       dividing_reg, dividing_next;
    cnt_t       count_reg, count_next;
    logic       pend_valid_reg, pend_valid_next;
    factor_t    pend_factor_reg, pend_factor_next;
    logic       pend_none_reg, pend_none_next;
    logic       out_valid_reg, out_valid_next;
    factor_t    out_factor_reg, out_factor_next;
    logic       out_none_reg, out_none_next;
    logic       out_last_reg, out_last_next;

    logic       div_start;
    div_stat_t  div_stat;

    logic       slot_free;
    logic       bound_fail;
    logic       can_emit;
    logic       emit_d;
    logic       emit_rem;
    logic       stall;
    rem_t       in_rem;

    pftd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rem_next),
        .divisor  (d_next),
        .stat     (div_stat)
    );

    // Decide what the finished division means
    always_comb
    begin
        in_rem     = rem_t'(din.value);
        slot_free  = !out_valid_reg || dout.ready;
        bound_fail = !dividing_reg && (rem_t'(d_reg) > div_stat.quot);
        can_emit   = count_reg < cnt_t'(MAX_RESULTS);
        emit_d     = !dividing_reg && !bound_fail && div_stat.rem_zero && can_emit;
        emit_rem   = bound_fail && (rem_reg > rem_t'(1)) && can_emit;
        stall      = (emit_d || emit_rem) && pend_valid_reg && !slot_free;
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        rem_next         = rem_reg;
        d_next           = d_reg;
        dividing_next    = dividing_reg;
        count_next       = count_reg;
        pend_valid_next  = pend_valid_reg;
        pend_factor_next = pend_factor_reg;
        pend_none_next   = pend_none_reg;
        out_valid_next   = out_valid_reg && !dout.ready;
        out_factor_next  = out_factor_reg;
        out_none_next    = out_none_reg;
        out_last_next    = out_last_reg;
        div_start        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (din.valid)
                begin
                    rem_next        = in_rem;
                    d_next          = div_t'(2);
                    dividing_next   = 1'b0;
                    count_next      = '0;
                    pend_valid_next = 1'b0;
                    if (in_rem <= rem_t'(1))
                    begin
                        pend_valid_next  = 1'b1;
                        pend_factor_next = '0;
                        pend_none_next   = 1'b1;
                        count_next       = cnt_t'(1);
                        state_next       = S_FLUSH;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (!div_stat.busy && !stall)
                begin
                    // Move the waiting factor out when a new one arrives
                    if ((emit_d || emit_rem) && pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_factor_next = pend_factor_reg;
                        out_none_next   = pend_none_reg;
                        out_last_next   = 1'b0;
                    end
                    if (emit_d || emit_rem)
                    begin
                        pend_valid_next  = 1'b1;
                        pend_factor_next = emit_d ? factor_t'(d_reg) : factor_t'(rem_reg);
                        pend_none_next   = 1'b0;
                        count_next       = count_reg + 1'b1;
                    end

                    if (bound_fail)
                        state_next = S_FLUSH;
                    else if (div_stat.rem_zero)
                    begin
                        // Divide the factor out and try it again
                        rem_next      = div_stat.quot;
                        dividing_next = 1'b1;
                        div_start     = 1'b1;
                    end
                    else
                    begin
                        // Advance to the next trial divisor
                        d_next        = d_reg + 1'b1;
                        dividing_next = 1'b0;
                        div_start     = 1'b1;
                    end
                end
            end
            S_FLUSH:
            begin
                if (slot_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_factor_next = pend_factor_reg;
                        out_none_next   = pend_none_reg;
                        out_last_next   = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            dividing_reg   <= 1'b0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            dividing_reg   <= dividing_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers hold no reset
    always_ff @(posedge clk)
    begin
        rem_reg         <= rem_next;
        d_reg           <= d_next;
        pend_factor_reg <= pend_factor_next;
        pend_none_reg   <= pend_none_next;
        out_factor_reg  <= out_factor_next;
        out_none_reg    <= out_none_next;
        out_last_reg    <= out_last_next;
    end

    assign din.ready      = (state_reg == S_IDLE);
    assign dout.valid     = out_valid_reg;
    assign dout.factor    = out_factor_reg;
    assign dout.no_factor = out_none_reg;
    assign dout.last      = out_last_reg;

`ifndef SYNTH
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("pending factor left over while idle");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(MAX_RESULTS))
        else $error("result count above cap");

    a_divisor_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (d_reg >= div_t'(2)))
        else $error("trial divisor below two");

    a_no_factor_word: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.no_factor) |-> (dout.last && (dout.factor == '0)))
        else $error("no-factor word must be last with zero factor");
`endif

endmodule

`default_nettype wire
